>>> sv/lmps_pkg.sv
// Package of the LED matrix pixel serializer: opcodes, register indexes,
// reset values, state types and the result record.
// No dependencies.
package lmps_pkg;

  localparam int DEF_MATRIX_WIDTH  = 16;
  localparam int DEF_MATRIX_HEIGHT = 16;

  // one byte per color channel, sent green, red, blue
  localparam int CHAN_N = 3;

  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [2:0] OP_WRITE = 3'd0;
  localparam logic [2:0] OP_READ  = 3'd1;
  localparam logic [2:0] OP_CLEAR = 3'd2;
  localparam logic [2:0] OP_SEND  = 3'd3;
  localparam logic [2:0] OP_TICK  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_WIRING    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 3'd4;

  localparam logic [3:0] RST_WIRING    = 4'd0;
  localparam logic [7:0] RST_BRIGHT    = 8'd255;
  localparam logic [7:0] RST_ZERO_HIGH = 8'd18;
  localparam logic [7:0] RST_ONE_HIGH  = 8'd45;
  localparam logic [7:0] RST_PERIOD    = 8'd63;

  // byte slot within a pixel, in line order
  localparam logic [1:0] CH_GREEN = 2'd0;
  localparam logic [1:0] CH_RED   = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_SEND
  } ctl_state_e;

  typedef enum logic [2:0] {
    PF_IDLE,
    PF_READ,
    PF_SEL,
    PF_MUL,
    PF_DONE
  } pf_state_e;

  typedef struct packed {
    logic        accepted;
    logic        busy;
    logic        level;
    logic [23:0] read_color;
  } res_t;

endpackage

>>> sv/lmps_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module lmps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/led_matrix_pixel_serializer_top.sv
// Top level of the LED matrix pixel serializer: frame store, serial bit
// engine, brightness prefetch and result queue. Uses lmps_pkg, lmps_ram.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid_i/tready_o     tuser op, tdata pixel item
//  m_axis    out  m_axis_tvalid_o/tready_i     tdata result
//  cfg       in   cfg_we_i (no stall)          cfg_idx_i, cfg_wdata_i
//
// Items are taken one per cycle while tready is high; results pass a stage
// register into a two-entry queue that keeps input open while they wait.
// After a start item the input stalls while the first byte is fetched and
// scaled (RAM read, select, four radix-4 multiply steps); later bytes are
// prefetched during the 8 bits of the byte before, so ticks run one per
// cycle unless a byte ends before its successor is scaled. After reset, a
// clearing pass zeroes the frame store, input stalled; cfg writes are taken.
module led_matrix_pixel_serializer_top
  import lmps_pkg::*;
#(
  parameter int MATRIX_WIDTH  = DEF_MATRIX_WIDTH,
  parameter int MATRIX_HEIGHT = DEF_MATRIX_HEIGHT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // tuser: op[2:0]
  // tdata: row[3:0], col[7:4], color[31:8], channel_mask[34:32], zero pad
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic [IN_USER_W-1:0]  s_axis_tuser_i,
  // tdata: read_color[23:0], line_level[24], busy_res[25], accepted[26], pad
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int PIX_N  = MATRIX_WIDTH * MATRIX_HEIGHT;
  localparam int PIX_AW = (PIX_N > 1) ? $clog2(PIX_N) : 1;
  localparam int BYTE_N = CHAN_N * PIX_N;
  localparam int POS_W  = $clog2(BYTE_N);
  localparam logic [PIX_AW-1:0] PIX_LAST   = PIX_AW'(PIX_N - 1);
  localparam logic [POS_W-1:0]  POS_LAST   = POS_W'(BYTE_N - 1);
  localparam logic [POS_W-1:0]  POS_PENULT = POS_W'(BYTE_N - 2);

  // Serpentine/straight chain ordering. wt[2]: rows run along the chain,
  // wt[1]/wt[3]: mirror column/row, wt[0] clear: every odd line reversed.
  function automatic logic [PIX_AW-1:0] chain_pos(input logic [3:0] wt,
                                                   input logic [3:0] i,
                                                   input logic [3:0] j);
    int ii;
    int jj;
    int a;
    int b;
    int major;
    int base;
    int minor;
    int len;
    int full;
    ii = int'(i);
    jj = int'(j);
    a  = MATRIX_WIDTH - 1 - jj;
    b  = MATRIX_HEIGHT - 1 - ii;
    if (wt[2]) begin
      major = wt[3] ? b : ii;
      base  = wt[1] ? a : jj;
      len   = MATRIX_WIDTH;
    end else begin
      major = wt[1] ? a : jj;
      base  = wt[3] ? b : ii;
      len   = MATRIX_HEIGHT;
    end
    if (!wt[0] && major[0]) begin
      minor = len - 1 - base;
    end else begin
      minor = base;
    end
    full = major * len + minor;
    return full[PIX_AW-1:0];
  endfunction

  // configuration
  logic [3:0] wiring_q;
  logic [7:0] bright_q;
  logic [7:0] zero_high_q;
  logic [7:0] one_high_q;
  logic [7:0] period_q;

  // control state
  ctl_state_e st_q, st_d;
  pf_state_e  pf_q, pf_d;
  logic [PIX_AW-1:0] sweep_q, sweep_d;

  // bit engine
  logic [7:0]       cycle_q, cycle_d;
  logic [2:0]       bit_q, bit_d;
  logic [7:0]       shift_q, shift_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             sh_valid_q, sh_valid_d;
  logic             clear_q, clear_d;

  // prefetch and brightness multiplier
  logic [PIX_AW-1:0] pf_pix_q, pf_pix_d;
  logic [1:0]        pf_ch_q, pf_ch_d;
  logic [7:0]        v_q, v_d;
  logic [15:0]       acc_q, acc_d;
  logic [1:0]        dig_q, dig_d;

  // result stage and queue
  logic stage_v_q;
  logic st_acc_q, st_busy_q, st_level_q, st_rd_q;
  res_t buf0_q, buf0_d, buf1_q, buf1_d;
  logic [1:0] cnt_q, cnt_d;

  // frame store ports
  logic [CHAN_N-1:0]            ram_we;
  logic [PIX_AW-1:0]            ram_waddr;
  logic [CHAN_N-1:0][7:0]       ram_wdata;
  logic [PIX_AW-1:0]            ram_raddr;
  logic [CHAN_N-1:0][7:0]       ram_rdata;

  // item fields
  logic [2:0]  op;
  logic [3:0]  row;
  logic [3:0]  col;
  logic [23:0] color;
  logic [2:0]  mask;
  logic        in_matrix;
  logic        op_known;
  logic [PIX_AW-1:0] item_addr;

  assign op    = s_axis_tuser_i[2:0];
  assign row   = s_axis_tdata_i[3:0];
  assign col   = s_axis_tdata_i[7:4];
  assign color = s_axis_tdata_i[31:8];
  assign mask  = s_axis_tdata_i[34:32];

  assign in_matrix = (int'(row) < MATRIX_HEIGHT) && (int'(col) < MATRIX_WIDTH);
  assign op_known  = op inside {OP_WRITE, OP_READ, OP_CLEAR, OP_SEND, OP_TICK};
  assign item_addr = chain_pos(wiring_q, row, col);

  // FSM outputs
  logic sweeping, idle, sending, pf_reading, pf_ready;

  always_comb begin : p_fsm_out
    sweeping   = (st_q == ST_SWEEP);
    idle       = (st_q == ST_IDLE);
    sending    = (st_q == ST_SEND);
    pf_reading = (pf_q == PF_READ);
    pf_ready   = (pf_q == PF_DONE);
  end

  // bit timing
  logic [7:0] period;
  logic [7:0] high_time;
  logic       tick_level;
  logic [8:0] cyc_inc;
  logic       bit_end;
  logic       byte_end;
  logic       last_byte;

  assign period     = (period_q == 8'd0) ? 8'd1 : period_q;
  assign high_time  = shift_q[7] ? one_high_q : zero_high_q;
  assign tick_level = (cycle_q < high_time);
  assign cyc_inc    = {1'b0, cycle_q} + 9'd1;
  assign bit_end    = (cyc_inc >= {1'b0, period});
  assign byte_end   = bit_end && (bit_q == 3'd7);
  assign last_byte  = (pos_q == POS_LAST);

  // handshake and events
  logic       s_fire, pop, tready_core;
  logic [2:0] occ;
  logic       start_go, tick_go, frame_done, byte_next, first_load;
  logic       pf_take, pf_more, pf_restart;

  assign pop = (cnt_q != 2'd0) && m_axis_tready_i;
  assign occ = {1'b0, cnt_q} + {2'b00, stage_v_q} - {2'b00, pop};
  // ticks stall before the first load and when a byte ends before pf_ready
  assign tready_core = idle ||
                       (sending && sh_valid_q && !(byte_end && !last_byte && !pf_ready));
  assign s_axis_tready_o = tready_core && (occ <= 3'd1);
  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;

  assign start_go   = s_fire && idle && ((op == OP_CLEAR) || (op == OP_SEND));
  assign tick_go    = s_fire && sending && (op == OP_TICK);
  assign frame_done = tick_go && byte_end && last_byte;
  assign byte_next  = tick_go && byte_end && !last_byte;
  assign first_load = sending && !sh_valid_q && pf_ready;
  assign pf_take    = byte_next || first_load;
  assign pf_more    = first_load || (pos_q != POS_PENULT);
  assign pf_restart = start_go || (pf_take && pf_more);

  // scaled = floor(acc / 255), exact for every acc up to 255*255
  logic [16:0] scale_sum;
  logic [7:0]  scaled;

  assign scale_sum = {1'b0, acc_q} + {9'b0, acc_q[15:8]} + 17'd1;
  assign scaled    = scale_sum[15:8];

  // multiplier digit
  logic [7:0] bright_sh;
  logic [9:0] pp;
  logic [7:0] pf_byte;

  assign bright_sh = bright_q >> {dig_q, 1'b0};

  always_comb begin : p_pp
    case (bright_sh[1:0])
      2'd0:    pp = 10'd0;
      2'd1:    pp = {2'b00, v_q};
      2'd2:    pp = {1'b0, v_q, 1'b0};
      default: pp = {2'b00, v_q} + {1'b0, v_q, 1'b0};
    endcase
  end

  always_comb begin : p_pf_sel
    case (pf_ch_q)
      CH_GREEN: pf_byte = ram_rdata[1];
      CH_RED:   pf_byte = ram_rdata[2];
      default:  pf_byte = ram_rdata[0];
    endcase
  end

  // next state: control
  always_comb begin : p_st_next
    st_d = st_q;
    case (st_q)
      ST_SWEEP: if (sweep_q == PIX_LAST) st_d = ST_IDLE;
      ST_IDLE:  if (start_go) st_d = ST_SEND;
      ST_SEND:  if (frame_done) st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  // next state: prefetch
  always_comb begin : p_pf_next
    pf_d = pf_q;
    case (pf_q)
      PF_IDLE: if (pf_restart) pf_d = PF_READ;
      PF_READ: pf_d = PF_SEL;
      PF_SEL:  pf_d = PF_MUL;
      PF_MUL:  if (dig_q == 2'd0) pf_d = PF_DONE;
      PF_DONE: begin
        if (pf_restart) begin
          pf_d = PF_READ;
        end else if (pf_take) begin
          pf_d = PF_IDLE;
        end
      end
      default: pf_d = PF_IDLE;
    endcase
  end

  always_comb begin : p_datapath
    sweep_d    = sweeping ? sweep_q + 1'b1 : sweep_q;
    cycle_d    = cycle_q;
    bit_d      = bit_q;
    shift_d    = shift_q;
    pos_d      = pos_q;
    sh_valid_d = sh_valid_q;
    clear_d    = clear_q;
    pf_pix_d   = pf_pix_q;
    pf_ch_d    = pf_ch_q;
    v_d        = v_q;
    acc_d      = acc_q;
    dig_d      = dig_q;

    if (start_go) begin
      pos_d      = '0;
      bit_d      = 3'd0;
      cycle_d    = 8'd0;
      sh_valid_d = 1'b0;
      clear_d    = (op == OP_CLEAR);
      pf_pix_d   = '0;
      pf_ch_d    = CH_GREEN;
    end

    if (first_load) begin
      shift_d    = scaled;
      sh_valid_d = 1'b1;
    end

    if (tick_go) begin
      if (bit_end) begin
        cycle_d = 8'd0;
        if (bit_q == 3'd7) begin
          bit_d = 3'd0;
          if (last_byte) begin
            pos_d      = '0;
            shift_d    = 8'd0;
            sh_valid_d = 1'b0;
            clear_d    = 1'b0;
          end else begin
            pos_d   = pos_q + 1'b1;
            shift_d = scaled;
          end
        end else begin
          bit_d   = bit_q + 3'd1;
          shift_d = {shift_q[6:0], 1'b0};
        end
      end else begin
        cycle_d = cyc_inc[7:0];
      end
    end

    if (pf_take && pf_more) begin
      if (pf_ch_q == CH_BLUE) begin
        pf_ch_d  = CH_GREEN;
        pf_pix_d = pf_pix_q + 1'b1;
      end else begin
        pf_ch_d = pf_ch_q + 2'd1;
      end
    end

    case (pf_q)
      PF_SEL: begin
        // a cleared frame sends zeros regardless of the old contents
        v_d   = clear_q ? 8'd0 : pf_byte;
        acc_d = 16'd0;
        dig_d = 2'd3;
      end
      PF_MUL: begin
        acc_d = {acc_q[13:0], 2'b00} + {6'b0, pp};
        dig_d = dig_q - 2'd1;
      end
      default: ;
    endcase
  end

  // frame store port muxing
  always_comb begin : p_ram_ctl
    ram_we    = '0;
    ram_waddr = item_addr;
    ram_wdata = color;
    ram_raddr = sending ? pf_pix_q : item_addr;
    if (sweeping) begin
      ram_we    = '1;
      ram_waddr = sweep_q;
      ram_wdata = '0;
    end else if (sending) begin
      // clear op: each pixel is zeroed as its bytes are fetched
      if (pf_reading && clear_q) begin
        ram_we    = '1;
        ram_waddr = pf_pix_q;
        ram_wdata = '0;
      end
    end else if (s_fire && (op == OP_WRITE) && in_matrix) begin
      ram_we = mask;
    end
  end

  for (genvar c = 0; c < CHAN_N; c++) begin : g_chan
    lmps_ram #(
      .WIDTH(8),
      .DEPTH(PIX_N)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (ram_we[c]),
      .waddr_i(ram_waddr),
      .wdata_i(ram_wdata[c]),
      .raddr_i(ram_raddr),
      .rdata_o(ram_rdata[c])
    );
  end

  // result queue
  res_t push_res;

  always_comb begin : p_queue
    push_res.accepted   = st_acc_q;
    push_res.busy       = st_busy_q;
    push_res.level      = st_level_q;
    push_res.read_color = st_rd_q ? ram_rdata : 24'd0;
    cnt_d  = cnt_q + {1'b0, stage_v_q} - {1'b0, pop};
    buf0_d = buf0_q;
    buf1_d = buf1_q;
    if (pop) begin
      buf0_d = buf1_q;
      if (stage_v_q) begin
        if (cnt_q == 2'd1) begin
          buf0_d = push_res;
        end else begin
          buf1_d = push_res;
        end
      end
    end else if (stage_v_q) begin
      if (cnt_q == 2'd0) begin
        buf0_d = push_res;
      end else begin
        buf1_d = push_res;
      end
    end
  end

  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign m_axis_tdata_o  = OUT_DATA_W'(buf0_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wiring_q    <= RST_WIRING;
      bright_q    <= RST_BRIGHT;
      zero_high_q <= RST_ZERO_HIGH;
      one_high_q  <= RST_ONE_HIGH;
      period_q    <= RST_PERIOD;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WIRING:    wiring_q    <= cfg_wdata_i[3:0];
        REG_BRIGHT:    bright_q    <= cfg_wdata_i;
        REG_ZERO_HIGH: zero_high_q <= cfg_wdata_i;
        REG_ONE_HIGH:  one_high_q  <= cfg_wdata_i;
        REG_PERIOD:    period_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_SWEEP;
      pf_q       <= PF_IDLE;
      sweep_q    <= '0;
      cycle_q    <= 8'd0;
      bit_q      <= 3'd0;
      shift_q    <= 8'd0;
      pos_q      <= '0;
      sh_valid_q <= 1'b0;
      clear_q    <= 1'b0;
      pf_pix_q   <= '0;
      pf_ch_q    <= CH_GREEN;
      dig_q      <= 2'd0;
      stage_v_q  <= 1'b0;
      cnt_q      <= 2'd0;
    end else begin
      st_q       <= st_d;
      pf_q       <= pf_d;
      sweep_q    <= sweep_d;
      cycle_q    <= cycle_d;
      bit_q      <= bit_d;
      shift_q    <= shift_d;
      pos_q      <= pos_d;
      sh_valid_q <= sh_valid_d;
      clear_q    <= clear_d;
      pf_pix_q   <= pf_pix_d;
      pf_ch_q    <= pf_ch_d;
      dig_q      <= dig_d;
      stage_v_q  <= s_fire;
      cnt_q      <= cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    acc_q  <= acc_d;
    buf0_q <= buf0_d;
    buf1_q <= buf1_d;
    if (s_fire) begin
      st_acc_q   <= op_known && ((op == OP_TICK) || !sending);
      st_busy_q  <= start_go || (sending && !frame_done);
      st_level_q <= tick_go && tick_level;
      st_rd_q    <= idle && (op == OP_READ) && in_matrix;
    end
  end

endmodule

>>> dv/led_matrix_pixel_serializer_top_tb.sv
`timescale 1ns / 1ps
// Testbench of led_matrix_pixel_serializer_top: pixel writes and reads under all
// wiring schemes and full frame transmissions checked tick by tick against a
// behavioral copy of the frame store and bit engine. Uses lmps_pkg and the RTL.
module led_matrix_pixel_serializer_top_tb;
  import lmps_pkg::*;

  localparam int PIXELS      = DEF_MATRIX_WIDTH * DEF_MATRIX_HEIGHT;
  localparam int FRAME_BYTES = PIXELS * CHAN_N;
  localparam int IDLE_LIMIT  = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 10;

  // opcodes the block does not know
  localparam logic [2:0] OP_UNDEF_LO = 3'd5;
  localparam logic [2:0] OP_UNDEF_HI = 3'd7;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [23:0] color;
    logic [2:0]  mask;
  } px_item_t;

  typedef struct {
    logic [3:0] wiring;
    logic [7:0] bright;
    logic [7:0] zero_hi;
    logic [7:0] one_hi;
    logic [7:0] period;
    logic [2:0] start_op;
    bit         gaps;
  } frame_plan_t;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic [IN_USER_W-1:0]  s_tuser   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // frame store and bit engine as the block should hold them
  logic [23:0] pix_mem [PIXELS];
  int unsigned byte_pos, bit_idx, cyc_cnt;
  logic [7:0]  shreg;
  bit          tx_busy;
  logic [3:0]  wiring;
  logic [7:0]  bright, zero_hi, one_hi, period;

  res_t pending_results[$];
  int   errors      = 0;
  int   result_no   = 0;
  int   quiet_cycles = 0;
  bit   src_gaps    = 1'b1;
  bit   snk_gaps    = 1'b1;
  bit   hold_start  = 1'b0;
  int   hold_left   = 0;

  led_matrix_pixel_serializer_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata)
  );

  always #4 clk_i = ~clk_i;

  function automatic void model_reset();
    foreach (pix_mem[k]) pix_mem[k] = '0;
    byte_pos = 0;
    bit_idx  = 0;
    cyc_cnt  = 0;
    shreg    = '0;
    tx_busy  = 1'b0;
    wiring   = RST_WIRING;
    bright   = RST_BRIGHT;
    zero_hi  = RST_ZERO_HIGH;
    one_hi   = RST_ONE_HIGH;
    period   = RST_PERIOD;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    case (idx)
      REG_WIRING:    wiring  = val[3:0];
      REG_BRIGHT:    bright  = val;
      REG_ZERO_HIGH: zero_hi = val;
      REG_ONE_HIGH:  one_hi  = val;
      REG_PERIOD:    period  = val;
      default: ;
    endcase
  endfunction

  // chain position of a pixel under the current wiring scheme
  function automatic int unsigned led_pos(int unsigned i, int unsigned j);
    int unsigned hgt, wid, a, b;
    bit je, ie, we_even, he_even;
    hgt = DEF_MATRIX_HEIGHT;
    wid = DEF_MATRIX_WIDTH;
    a = wid - 1 - j;
    b = hgt - 1 - i;
    je = (j % 2) == 0;
    ie = (i % 2) == 0;
    we_even = ((wid - j) % 2) == 0;
    he_even = ((hgt - i) % 2) == 0;
    case (wiring)
      4'd0:    return j * hgt + (je ? i : b);
      4'd1:    return j * hgt + i;
      4'd2:    return a * hgt + (we_even ? b : i);
      4'd3:    return a * hgt + i;
      4'd4:    return i * wid + (ie ? j : a);
      4'd5:    return i * wid + j;
      4'd6:    return i * wid + (ie ? a : j);
      4'd7:    return i * wid + a;
      4'd8:    return j * hgt + (je ? b : i);
      4'd9:    return j * hgt + b;
      4'd10:   return a * hgt + (we_even ? i : b);
      4'd11:   return a * hgt + b;
      4'd12:   return b * wid + (he_even ? a : j);
      4'd13:   return b * wid + j;
      4'd14:   return b * wid + (he_even ? j : a);
      default: return b * wid + a;
    endcase
  endfunction

  // brightness is taken as each byte enters the shifter
  function automatic void load_shift_byte();
    logic [23:0] px;
    logic [7:0]  v;
    logic [15:0] prod;
    px = pix_mem[(byte_pos / CHAN_N) % PIXELS];
    case (2'(byte_pos % CHAN_N))
      CH_GREEN: v = px[15:8];
      CH_RED:   v = px[23:16];
      default:  v = px[7:0];
    endcase
    prod  = v * bright;
    shreg = 8'(prod / 16'd255);
  endfunction

  function automatic void start_frame();
    tx_busy  = 1'b1;
    byte_pos = 0;
    bit_idx  = 0;
    cyc_cnt  = 0;
    load_shift_byte();
  endfunction

  function automatic res_t apply_item(px_item_t it);
    res_t        r;
    logic [23:0] keep;
    int unsigned idx, per, hi;
    r = '0;
    r.accepted = 1'b1;
    if (it.op <= OP_SEND && tx_busy) begin
      r.accepted = 1'b0;
    end else begin
      case (it.op)
        OP_WRITE: begin
          keep = {{8{~it.mask[2]}}, {8{~it.mask[1]}}, {8{~it.mask[0]}}};
          idx = led_pos(it.row, it.col);
          pix_mem[idx] = (pix_mem[idx] & keep) | (it.color & ~keep);
        end
        OP_READ: r.read_color = pix_mem[led_pos(it.row, it.col)];
        OP_CLEAR: begin
          foreach (pix_mem[k]) pix_mem[k] = '0;
          start_frame();
        end
        OP_SEND: start_frame();
        OP_TICK: begin
          if (tx_busy) begin
            per = (period < 1) ? 1 : period;
            hi = shreg[7] ? one_hi : zero_hi;
            r.level = cyc_cnt < hi;
            cyc_cnt++;
            if (cyc_cnt >= per) begin
              cyc_cnt = 0;
              if (bit_idx >= 7) begin
                bit_idx = 0;
                byte_pos++;
                if (byte_pos >= FRAME_BYTES) begin
                  tx_busy  = 1'b0;
                  byte_pos = 0;
                  shreg    = '0;
                end else begin
                  load_shift_byte();
                end
              end else begin
                bit_idx++;
                shreg = shreg << 1;
              end
            end
          end
        end
        default: r.accepted = 1'b0;
      endcase
    end
    r.busy = tx_busy;
    return r;
  endfunction

  function automatic void report_error(string msg);
    if (errors < MAX_REPORTS) $display("ERROR: %s", msg);
    errors++;
  endfunction

  // prediction on each input transfer, comparison on each output transfer
  always @(posedge clk_i) begin : result_monitor
    px_item_t it;
    res_t     want, got;
    string    bad;
    if (rst_ni) begin
      if (cfg_we) apply_reg(cfg_idx, cfg_wdata);
      if (s_tvalid && s_tready) begin
        it.op    = s_tuser;
        it.row   = s_tdata[3:0];
        it.col   = s_tdata[7:4];
        it.color = s_tdata[31:8];
        it.mask  = s_tdata[34:32];
        pending_results.push_back(apply_item(it));
      end
      if (m_tvalid && m_tready) begin
        got = res_t'(m_tdata[$bits(res_t)-1:0]);
        if (pending_results.size() == 0) begin
          report_error($sformatf("result %0d arrived with none expected: %h", result_no, got));
        end else begin
          want = pending_results.pop_front();
          bad = "";
          if (got.read_color !== want.read_color) bad = {bad, " read_color"};
          if (got.level !== want.level) bad = {bad, " line_level"};
          if (got.busy !== want.busy) bad = {bad, " busy"};
          if (got.accepted !== want.accepted) bad = {bad, " accepted"};
          if (bad != "")
            report_error($sformatf(
                "result %0d wrong%s: exp color=%h lvl=%b busy=%b acc=%b, got color=%h lvl=%b busy=%b acc=%b",
                result_no, bad, want.read_color, want.level, want.busy, want.accepted,
                got.read_color, got.level, got.busy, got.accepted));
        end
        result_no++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: random stalls plus an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_start) begin
      hold_left  = HOLD_CYCLES;
      hold_start = 1'b0;
    end
    if (hold_left > 0) begin
      m_tready = 1'b0;
      hold_left--;
    end else begin
      m_tready = !(snk_gaps && $urandom_range(99) < 30);
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(input px_item_t it);
    if (src_gaps) begin
      while ($urandom_range(99) < 30) begin
        s_tvalid = 1'b0;
        @(negedge clk_i);
      end
    end
    s_tvalid = 1'b1;
    s_tuser  = it.op;
    s_tdata  = IN_DATA_W'({it.mask, it.color, it.col, it.row});
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
    s_tvalid = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = val;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  // sender stops until every expected result is back
  task automatic drain();
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  function automatic px_item_t mk(logic [2:0] op, logic [3:0] row, logic [3:0] col,
                                  logic [23:0] color, logic [2:0] mask);
    px_item_t it;
    it.op    = op;
    it.row   = row;
    it.col   = col;
    it.color = color;
    it.mask  = mask;
    return it;
  endfunction

  function automatic px_item_t rand_idle_item();
    px_item_t    it;
    int unsigned pick;
    it = mk(OP_WRITE, 4'($urandom), 4'($urandom), 24'($urandom), 3'($urandom));
    pick = $urandom_range(99);
    if (pick < 45)      it.op = OP_WRITE;
    else if (pick < 85) it.op = OP_READ;
    else if (pick < 94) it.op = OP_TICK;
    else                it.op = 3'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
    return it;
  endfunction

  // mostly ticks; the rest must be refused while the frame goes out
  function automatic px_item_t rand_busy_item();
    px_item_t it;
    it = mk(OP_TICK, 4'($urandom), 4'($urandom), 24'($urandom), 3'($urandom));
    if ($urandom_range(99) < 4) begin
      it.op = 3'($urandom_range(0, 6));
      if (it.op >= OP_TICK) it.op = it.op + 3'd1;
    end
    return it;
  endfunction

  task automatic test_directed();
    send_item(mk(OP_TICK, 4'd0, 4'd0, 24'h000000, 3'd0));
    for (int op = OP_UNDEF_LO; op <= OP_UNDEF_HI; op++)
      send_item(mk(3'(op), 4'd15, 4'd15, 24'hFFFFFF, 3'd7));
    send_item(mk(OP_WRITE, 4'd0,  4'd0,  24'hFFFFFF, 3'd7));
    send_item(mk(OP_WRITE, 4'd15, 4'd15, 24'h123456, 3'd7));
    send_item(mk(OP_WRITE, 4'd0,  4'd15, 24'hA5C3E1, 3'd5));
    send_item(mk(OP_WRITE, 4'd15, 4'd0,  24'hFFFFFF, 3'd0));
    send_item(mk(OP_WRITE, 4'd0,  4'd0,  24'h000000, 3'd2));
    send_item(mk(OP_WRITE, 4'd15, 4'd15, 24'hFFFFFF, 3'd4));
    send_item(mk(OP_WRITE, 4'd0,  4'd15, 24'h5A3C1E, 3'd1));
    send_item(mk(OP_READ,  4'd0,  4'd0,  24'hFFFFFF, 3'd7));
    send_item(mk(OP_READ,  4'd15, 4'd15, 24'h000000, 3'd0));
    send_item(mk(OP_READ,  4'd0,  4'd15, 24'h000000, 3'd0));
    send_item(mk(OP_READ,  4'd15, 4'd0,  24'h000000, 3'd0));
    send_item(mk(OP_READ,  4'd7,  4'd8,  24'h000000, 3'd0));
    send_item(mk(OP_TICK,  4'd15, 4'd15, 24'hFFFFFF, 3'd7));
  endtask

  task automatic test_wiring();
    for (int w = 0; w < 16; w++) begin
      drain();
      write_reg(REG_WIRING, 8'(w));
      repeat (60) send_item(rand_idle_item());
    end
  endtask

  task automatic run_frame(input logic [2:0] start_op);
    send_item(mk(start_op, 4'($urandom), 4'($urandom), 24'($urandom), 3'($urandom)));
    while (tx_busy) send_item(rand_busy_item());
  endtask

  task automatic test_frames();
    frame_plan_t plan[6];
    plan = '{
      '{4'd3,  8'd255, 8'd1,   8'd1,   8'd2, OP_SEND,  1'b1},
      '{4'd12, 8'd0,   8'd0,   8'd1,   8'd1, OP_SEND,  1'b1},
      '{4'd6,  8'd128, 8'd1,   8'd2,   8'd3, OP_CLEAR, 1'b1},
      '{4'd9,  8'd1,   8'd255, 8'd255, 8'd2, OP_SEND,  1'b0},
      '{4'd15, 8'd200, 8'd2,   8'd3,   8'd4, OP_SEND,  1'b1},
      '{4'd0,  8'd255, 8'd1,   8'd0,   8'd0, OP_SEND,  1'b1}
    };
    foreach (plan[p]) begin
      drain();
      write_reg(REG_WIRING, 8'(plan[p].wiring));
      write_reg(REG_BRIGHT, plan[p].bright);
      write_reg(REG_ZERO_HIGH, plan[p].zero_hi);
      write_reg(REG_ONE_HIGH, plan[p].one_hi);
      write_reg(REG_PERIOD, plan[p].period);
      repeat (100) send_item(rand_idle_item());
      // one frame goes out, back to back on both sides if the plan has no gaps
      src_gaps = plan[p].gaps;
      snk_gaps = plan[p].gaps;
      run_frame(plan[p].start_op);
      src_gaps = 1'b1;
      snk_gaps = 1'b1;
      repeat (30) send_item(rand_idle_item());
    end
  endtask

  task automatic test_backpressure();
    drain();
    write_reg(REG_PERIOD, 8'd255);
    write_reg(REG_ONE_HIGH, 8'd255);
    write_reg(REG_ZERO_HIGH, 8'd1);
    write_reg(REG_WIRING, 8'd15);
    hold_start = 1'b1;
    repeat (60) send_item(rand_idle_item());
    drain();
  endtask

  initial begin
    model_reset();
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_wiring();
    test_frames();
    test_backpressure();
    drain();
    repeat (20) @(negedge clk_i);
    if (errors == 0 && pending_results.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

>>> filelist.f
sv/lmps_pkg.sv
sv/lmps_ram.sv
sv/led_matrix_pixel_serializer_top.sv
dv/led_matrix_pixel_serializer_top_tb.sv
